// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file.
// Depends on nothing; each use expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define SWE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition never occurs at a clock edge outside reset.
`define SWE_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hdl/swe_pkg.sv -----
// Shared types, constants and the UART byte encoding for the write frame encoder.
// No dependencies.
package swe_pkg;

    localparam int KIND_W     = 2;
    localparam int ADDR_W     = 24;
    localparam int BYTE_W     = 8;
    localparam int ENC_LEN    = 5;   // UART bytes per logical byte
    localparam int HDR_LEN    = 5;   // logical bytes in a start header
    localparam int POS_W      = 3;
    localparam int IDX_W      = 3;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = 2;
    localparam int Q_CNT_W    = 3;

    localparam logic [BYTE_W-1:0] BASE_FIRST = 8'hE8;
    localparam logic [BYTE_W-1:0] BASE_REST  = 8'hEF;
    localparam logic [BYTE_W-1:0] MASK_HI    = 8'hE8;
    localparam logic [BYTE_W-1:0] MASK_LO    = 8'h0F;
    localparam logic [BYTE_W-1:0] HDR_SYNC   = 8'h5A;
    localparam logic [BYTE_W-1:0] HDR_TAIL   = 8'h00;
    localparam logic [BYTE_W-1:0] END_BYTE   = 8'hFF;

    typedef enum logic [KIND_W-1:0] {
        KIND_START = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_END   = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    // One logical byte waiting for expansion.
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              first;
        logic              last;
    } lbyte_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [BYTE_W-1:0] enc_uart(input logic [BYTE_W-1:0] v,
                                                   input logic              first,
                                                   input logic [POS_W-1:0]  pos);
        logic [BYTE_W-1:0] b;
        b = BASE_REST;
        case (pos)
            3'd0:
            begin
                b = first ? BASE_FIRST : BASE_REST;
                if (v[7]) b = b & MASK_LO;
            end
            3'd1:
            begin
                if (v[6]) b = b & MASK_HI;
                if (v[5]) b = b & MASK_LO;
            end
            3'd2:
            begin
                if (v[4]) b = b & MASK_HI;
                if (v[3]) b = b & MASK_LO;
            end
            3'd3:
            begin
                if (v[2]) b = b & MASK_HI;
                if (v[1]) b = b & MASK_LO;
            end
            3'd4:
            begin
                if (v[0]) b = b & MASK_HI;
            end
            default:
            begin
                b = BASE_REST;
            end
        endcase
        return b;
    endfunction

endpackage

// ----- hdl/sws_write_frame_encoder.sv -----
// Channel   Handshake             Payload
// input     start / busy          kind, address, data_byte
// output    strobe (one cycle)    uart_byte, last
//
// A data or end transaction yields 5 UART bytes, a start transaction 25, one per
// cycle; the back end's one-byte-per-cycle output sets the data rate. With the
// queue empty, strobe rises after the front-end, queue and current-byte registers.
// busy stays high until a transaction's final logical byte enters the 4-entry queue.
// The receiver cannot stall; results are never held. Reset clears all control state.
// Top level: front end, logical-byte queue, back end. Depends on swe_pkg.
module sws_write_frame_encoder (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [swe_pkg::KIND_W-1:0]  kind,
    input  logic [swe_pkg::ADDR_W-1:0]  address,
    input  logic [swe_pkg::BYTE_W-1:0]  data_byte,
    output logic                        strobe,
    output logic [swe_pkg::BYTE_W-1:0]  uart_byte,
    output logic                        last
);
    import swe_pkg::*;

    logic     push;
    lbyte_t   push_entry;
    logic     pop;
    lbyte_t   head;
    q_stat_t  q_stat;

    swe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .address    (address),
        .data_byte  (data_byte),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    swe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    swe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_stat     (q_stat),
        .pop        (pop),
        .strobe     (strobe),
        .uart_byte  (uart_byte),
        .last       (last)
    );

endmodule

// ----- hdl/swe_front.sv -----
// Front end: takes start/data/end transactions and splits them into logical bytes.
// Depends on swe_pkg.
module swe_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [swe_pkg::KIND_W-1:0]   kind,
    input  logic [swe_pkg::ADDR_W-1:0]   address,
    input  logic [swe_pkg::BYTE_W-1:0]   data_byte,
    input  swe_pkg::q_stat_t             q_stat,
    output logic                         push,
    output swe_pkg::lbyte_t              push_entry
);
    import swe_pkg::*;

    logic               active_reg, active_next;
    kind_t              kind_reg, kind_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [BYTE_W-1:0]  data_reg, data_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               accept;
    logic               item_done;

    always_comb
    begin
        push_entry = '{value: HDR_TAIL, first: 1'b0, last: 1'b0};
        case (kind_reg)
            KIND_START:
            begin
                push_entry.last = (idx_reg == IDX_W'(HDR_LEN - 1));
                case (idx_reg)
                    3'd0:
                    begin
                        push_entry.value = HDR_SYNC;
                        push_entry.first = 1'b1;
                    end
                    3'd1:    push_entry.value = addr_reg[23:16];
                    3'd2:    push_entry.value = addr_reg[15:8];
                    3'd3:    push_entry.value = addr_reg[7:0];
                    default: push_entry.value = HDR_TAIL;
                endcase
            end
            KIND_DATA:
            begin
                push_entry.value = data_reg;
                push_entry.last  = 1'b1;
            end
            KIND_END:
            begin
                push_entry.value = END_BYTE;
                push_entry.first = 1'b1;
                push_entry.last  = 1'b1;
            end
            default:
            begin
                push_entry.last = 1'b1;
            end
        endcase
    end

    assign push      = active_reg && !q_stat.full;
    assign item_done = push && push_entry.last;
    // Free again in the cycle the final logical byte goes into the queue.
    assign busy      = active_reg && !item_done;
    assign accept    = start && !busy;

    always_comb
    begin
        active_next = active_reg;
        kind_next   = kind_reg;
        addr_next   = addr_reg;
        data_next   = data_reg;
        idx_next    = idx_reg;
        if (accept)
        begin
            // Unused kind code is taken and dropped.
            active_next = (kind_t'(kind) != KIND_NONE);
            kind_next   = kind_t'(kind);
            addr_next   = address;
            data_next   = data_byte;
            idx_next    = '0;
        end
        else if (push)
        begin
            idx_next = idx_reg + IDX_W'(1);
            if (push_entry.last) active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            kind_reg   <= KIND_NONE;
            idx_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            kind_reg   <= kind_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        data_reg <= data_next;
    end

endmodule

// ----- hdl/swe_queue.sv -----
// Short FIFO of logical bytes between the front and back ends.
// Depends on swe_pkg.
module swe_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  swe_pkg::lbyte_t   push_entry,
    input  logic              pop,
    output swe_pkg::lbyte_t   head,
    output swe_pkg::q_stat_t  q_stat
);
    import swe_pkg::*;

    lbyte_t              mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign q_stat.full  = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) cnt_next = cnt_reg + Q_CNT_W'(1);
        else if (do_pop && !do_push) cnt_next = cnt_reg - Q_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// ----- hdl/swe_back.sv -----
// Back end: expands each logical byte into five UART bytes, one per cycle.
// Depends on swe_pkg (enc_uart).
module swe_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  swe_pkg::lbyte_t             head,
    input  swe_pkg::q_stat_t            q_stat,
    output logic                        pop,
    output logic                        strobe,
    output logic [swe_pkg::BYTE_W-1:0]  uart_byte,
    output logic                        last
);
    import swe_pkg::*;

    logic               cur_valid_reg, cur_valid_next;
    lbyte_t             cur_reg, cur_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               strobe_reg, strobe_next;
    logic [BYTE_W-1:0]  uart_byte_reg, uart_byte_next;
    logic               last_reg, last_next;
    logic               at_end;

    assign at_end = (pos_reg == POS_W'(ENC_LEN - 1));
    // Refill on the final UART byte so entries run back to back.
    assign pop    = !q_stat.empty && (!cur_valid_reg || at_end);

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        pos_next       = pos_reg;
        strobe_next    = cur_valid_reg;
        uart_byte_next = enc_uart(cur_reg.value, cur_reg.first, pos_reg);
        last_next      = cur_valid_reg && cur_reg.last && at_end;
        if (cur_valid_reg)
            pos_next = pos_reg + POS_W'(1);
        if (cur_valid_reg && at_end)
            cur_valid_next = 1'b0;
        if (pop)
        begin
            cur_valid_next = 1'b1;
            cur_next       = head;
            pos_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            pos_reg       <= '0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            pos_reg       <= pos_next;
            strobe_reg    <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        uart_byte_reg <= uart_byte_next;
        last_reg      <= last_next;
    end

    assign strobe    = strobe_reg;
    assign uart_byte = uart_byte_reg;
    assign last      = strobe_reg && last_reg;

endmodule

// ----- hdl/swe_checker.sv -----
// Port-level checks for the write frame encoder, bound to the top level.
// Depends on swe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module swe_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic [swe_pkg::KIND_W-1:0]  kind,
    input  logic                        strobe,
    input  logic [swe_pkg::BYTE_W-1:0]  uart_byte,
    input  logic                        last
);
    import swe_pkg::*;

    `SWE_NEVER(a_last_needs_strobe, last && !strobe, "last without strobe")
    `SWE_ASSERT(a_hi, strobe |-> (uart_byte[7:4] == 4'hE || uart_byte[7:4] == 4'h0), "bad hi")
    `SWE_ASSERT(a_lo, strobe |-> (uart_byte[3:0] == 4'h8 || uart_byte[3:0] == 4'hF), "bad lo")
    `SWE_ASSERT(a_drop_unused, (start && !busy && kind == KIND_NONE) |=> !busy, "unused kind")

endmodule

bind sws_write_frame_encoder swe_checker u_swe_checker (.*);
